@@ hdl/ip_address_text_validator_macros.svh @@
// ----------------------------------------------------------------------------
// ip_address_text_validator assertion macros
// Immediate-consequence and next-cycle property wrappers, compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IPAV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipav assertion failed");
`define IPAV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipav assertion failed");
`else
`define IPAV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IPAV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/ipav_pkg.sv @@
// ----------------------------------------------------------------------------
// ipav_pkg
// Shared types and constants of the IP address text validator.
// ----------------------------------------------------------------------------
package ipav_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_item;

    typedef struct packed {
        logic       hex_rejected;
        logic       dec_rejected;
        logic [8:0] octet_value;
        logic [2:0] dot_count;
        logic [2:0] group_digits;
        logic [1:0] colon_run;
        logic [3:0] group_count;
        logic       seen_double_colon;
        logic       in_dotted_tail;
        logic [3:0] groups_before_tail;
    } t_state;

    localparam logic [8:0] C_OCTET_NONE       = 9'h1FF;
    localparam logic [8:0] C_OCTET_MAX        = 9'd255;
    localparam logic [2:0] C_IPV4_DOTS        = 3'd3;
    localparam logic [3:0] C_TAIL_GROUPS      = 4'd6;
    localparam logic [3:0] C_FULL_GROUPS      = 4'd8;
    localparam logic [2:0] C_GROUP_MAX_DIGITS = 3'd4;
    localparam logic [3:0] C_GROUP_SAT        = 4'd9;
    localparam logic [2:0] C_DOT_SAT          = 3'd7;
    localparam logic [2:0] C_DIGITS_SAT       = 3'd7;
    localparam logic [1:0] C_COLON_SAT        = 2'd3;

    localparam logic       C_MODE_IPV4        = 1'b0;
    localparam logic       C_MODE_IPV6        = 1'b1;

    localparam logic [7:0] C_CH_DOT           = 8'h2E;
    localparam logic [7:0] C_CH_COLON         = 8'h3A;

    localparam t_state C_STATE_RESET = '{
        hex_rejected:       1'b0,
        dec_rejected:       1'b0,
        octet_value:        C_OCTET_NONE,
        dot_count:          3'd0,
        group_digits:       3'd0,
        colon_run:          2'd0,
        group_count:        4'd0,
        seen_double_colon:  1'b0,
        in_dotted_tail:     1'b0,
        groups_before_tail: 4'd0
    };

endpackage

@@ hdl/ipav_in_stage.sv @@
// ----------------------------------------------------------------------------
// ipav_in_stage
// Input register: holds one character transaction until the checker takes it.
// ----------------------------------------------------------------------------
module ipav_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ipav_pkg::t_item i_item,
    input  logic           i_adv,
    output logic           o_valid,
    output ipav_pkg::t_item o_item
);

    logic            r_valid;
    ipav_pkg::t_item r_item;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hdl/ipav_core.sv @@
// ----------------------------------------------------------------------------
// ipav_core
// Per-character state update for the dotted-decimal and hex group checkers,
// with the verdict for the item marked last.
// ----------------------------------------------------------------------------
`include "ip_address_text_validator_macros.svh"

module ipav_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_mode,
    input  logic            i_adv,
    input  ipav_pkg::t_item i_item,
    output logic            o_verdict
);

    ipav_pkg::t_state r_state;
    ipav_pkg::t_state n_state;
    ipav_pkg::t_state w_step;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic ipav_pkg::t_state dec_step(input ipav_pkg::t_state s,
                                                  input logic [7:0] c);
        ipav_pkg::t_state r;
        logic [11:0]      v;
        r = s;
        // '0'..'9' carry their value in the low nibble
        v = 12'(s.octet_value) * 12'd10 + 12'(c[3:0]);
        if (!s.dec_rejected) begin
            if (c == ipav_pkg::C_CH_DOT) begin
                if (s.dot_count != ipav_pkg::C_DOT_SAT) begin
                    r.dot_count = s.dot_count + 3'd1;
                end
                if (s.octet_value == ipav_pkg::C_OCTET_NONE) begin
                    r.dec_rejected = 1'b1;
                end
                r.octet_value = ipav_pkg::C_OCTET_NONE;
            end else if (is_dec(c)) begin
                if (s.octet_value == 9'd0) begin
                    r.dec_rejected = 1'b1;     // leading zero
                end else if (s.octet_value == ipav_pkg::C_OCTET_NONE) begin
                    r.octet_value = {5'd0, c[3:0]};
                end else if (v > 12'(ipav_pkg::C_OCTET_MAX)) begin
                    r.dec_rejected = 1'b1;
                end else begin
                    r.octet_value = v[8:0];
                end
            end else begin
                r.dec_rejected = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic ipav_pkg::t_state hex_step(input ipav_pkg::t_state s,
                                                  input logic [7:0] c);
        ipav_pkg::t_state r;
        r = s;
        if (!s.hex_rejected) begin
            if (c == ipav_pkg::C_CH_COLON) begin
                if (s.colon_run == 2'd0) begin
                    if (s.group_digits != 3'd0) begin
                        r.group_digits = 3'd0;
                        if (s.group_count < ipav_pkg::C_GROUP_SAT) begin
                            r.group_count = s.group_count + 4'd1;
                        end
                    end
                end else if (s.colon_run == 2'd1) begin
                    if (s.seen_double_colon) begin
                        r.hex_rejected = 1'b1;
                    end
                    r.seen_double_colon = 1'b1;
                end else begin
                    r.hex_rejected = 1'b1;
                end
                if (s.colon_run != ipav_pkg::C_COLON_SAT) begin
                    r.colon_run = s.colon_run + 2'd1;
                end
                // new group: restart its decimal view
                r.dec_rejected = 1'b0;
                r.octet_value  = ipav_pkg::C_OCTET_NONE;
                r.dot_count    = 3'd0;
            end else if (is_hex(c)) begin
                // single leading colon
                if (s.colon_run == 2'd1 && s.group_count == 4'd0) begin
                    r.hex_rejected = 1'b1;
                end
                if (s.group_digits >= ipav_pkg::C_GROUP_MAX_DIGITS) begin
                    r.hex_rejected = 1'b1;
                end
                r.colon_run = 2'd0;
                if (s.group_digits != ipav_pkg::C_DIGITS_SAT) begin
                    r.group_digits = s.group_digits + 3'd1;
                end
                r = dec_step(r, c);
            end else if (c == ipav_pkg::C_CH_DOT) begin
                r.in_dotted_tail     = 1'b1;
                r.groups_before_tail = s.group_count;
                r = dec_step(r, c);
            end else begin
                r.hex_rejected = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic dec_ok(input ipav_pkg::t_state s);
        return !s.dec_rejected && (s.dot_count == ipav_pkg::C_IPV4_DOTS) &&
               (s.octet_value != ipav_pkg::C_OCTET_NONE);
    endfunction

    function automatic logic hex_ok(input ipav_pkg::t_state s);
        logic [3:0] blocks;
        logic       ok;
        blocks = s.group_count;
        if (s.group_digits != 3'd0 && s.group_count < ipav_pkg::C_GROUP_SAT) begin
            blocks = s.group_count + 4'd1;
        end
        if (s.hex_rejected) begin
            ok = 1'b0;
        end else if (s.in_dotted_tail) begin
            ok = dec_ok(s) && (s.seen_double_colon ?
                               (s.groups_before_tail < ipav_pkg::C_TAIL_GROUPS) :
                               (s.groups_before_tail == ipav_pkg::C_TAIL_GROUPS));
        end else if (s.colon_run == 2'd1) begin
            ok = 1'b0;
        end else begin
            ok = s.seen_double_colon ? (blocks < ipav_pkg::C_FULL_GROUPS) :
                                       (blocks == ipav_pkg::C_FULL_GROUPS);
        end
        return ok;
    endfunction

    always_comb begin
        if (i_mode == ipav_pkg::C_MODE_IPV4 || r_state.in_dotted_tail) begin
            w_step = dec_step(r_state, i_item.ch);
        end else begin
            w_step = hex_step(r_state, i_item.ch);
        end
        o_verdict = (i_mode == ipav_pkg::C_MODE_IPV6) ? hex_ok(w_step) : dec_ok(w_step);
        n_state   = i_item.last ? ipav_pkg::C_STATE_RESET : w_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipav_pkg::C_STATE_RESET;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    `IPAV_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, i_adv && i_item.last, r_state == ipav_pkg::C_STATE_RESET)
    `IPAV_ASSERT_IMP(a_count_sat, i_clk, i_rst_n, 1'b1, (r_state.group_count <= ipav_pkg::C_GROUP_SAT) && (r_state.groups_before_tail <= ipav_pkg::C_GROUP_SAT))
    `IPAV_ASSERT_IMP(a_tail_on_dot, i_clk, i_rst_n, $rose(r_state.in_dotted_tail), $past(i_adv && (i_item.ch == ipav_pkg::C_CH_DOT)))

endmodule

@@ hdl/ip_address_text_validator.sv @@
// ----------------------------------------------------------------------------
// ip_address_text_validator
// Streams address text one character per transaction and returns a single
// valid/invalid verdict on the character marked last (IPv4 or IPv6 mode).
// ----------------------------------------------------------------------------
//   channel   direction  handshake            payload
//   char in   input      i_valid / o_ready    i_ch[7:0], i_last
//   verdict   output     o_valid / i_ready    o_valid_res
//   mode cfg  input      i_cfg_we             i_cfg_data (0 = IPv4, 1 = IPv6)
//
// One character per cycle sustained, except while a last character holds; the
// verdict is registered through the checker update into the result register.
// Reset clears the checker state and sets mode to IPv6.
// Non-last characters keep flowing while a verdict waits; a last character
// holds in the input register only while the result register is still full.
// ----------------------------------------------------------------------------
`include "ip_address_text_validator_macros.svh"

module ip_address_text_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_valid_res,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    logic            r_mode;
    logic            r_out_valid;
    logic            r_valid_res;
    logic            w_stage_valid;
    logic            w_adv;
    logic            w_verdict;
    ipav_pkg::t_item w_in_item;
    ipav_pkg::t_item w_item;

    assign w_in_item.ch   = i_ch;
    assign w_in_item.last = i_last;

    // a last character needs room in the result register
    assign w_adv = w_stage_valid && (!w_item.last || !r_out_valid || i_ready);

    ipav_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (w_in_item),
        .i_adv   (w_adv),
        .o_valid (w_stage_valid),
        .o_item  (w_item)
    );

    ipav_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_adv     (w_adv),
        .i_item    (w_item),
        .o_verdict (w_verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ipav_pkg::C_MODE_IPV6;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_item.last) begin
            r_valid_res <= w_verdict;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_valid_res;

    `IPAV_ASSERT_IMP(a_out_from_last, i_clk, i_rst_n, $rose(o_valid), $past(w_adv && w_item.last))
    `IPAV_ASSERT_IMP(a_full_stage_moves, i_clk, i_rst_n, i_valid && o_ready && w_stage_valid, w_adv)

endmodule
